[src/smm_pkg.sv]
package smm_pkg;

  localparam int unsigned COORD_W = 3;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned PROD_W  = 2 * VALUE_W;
  localparam int unsigned SUM_W   = 35;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned DIM_DEFAULT = 8;

  localparam logic [CMD_W-1:0] CMD_WRITE_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MULTIPLY = 2'd2;

  typedef struct packed {
    logic                      a_en;
    logic                      b_en;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic signed [VALUE_W-1:0] value;
  } wr_t;

  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic [COORD_W-1:0]      row;
    logic [COORD_W-1:0]      col;
    logic signed [SUM_W-1:0] sum;
  } tok_t;

endpackage

[src/smm_cell.sv]
module smm_cell #(
  parameter int unsigned DIM     = smm_pkg::DIM_DEFAULT,
  parameter int unsigned CELL_ID = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  smm_pkg::wr_t  wr_i,
  input  smm_pkg::tok_t tok_i,
  output smm_pkg::tok_t tok_o
);

  localparam int unsigned IDX_W = (DIM > 1) ? $clog2(DIM) : 1;

  // column CELL_ID of A, row CELL_ID of B
  logic signed [smm_pkg::VALUE_W-1:0] a_mem [DIM];
  logic signed [smm_pkg::VALUE_W-1:0] b_mem [DIM];

  smm_pkg::tok_t                      mid_q, mid_d;
  smm_pkg::tok_t                      out_q, out_d;
  logic signed [smm_pkg::PROD_W-1:0]  prod_q, prod_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.a_en && wr_i.col == smm_pkg::COORD_W'(CELL_ID)) begin
      a_mem[wr_i.row[IDX_W-1:0]] <= wr_i.value;
    end
    if (wr_i.b_en && wr_i.row == smm_pkg::COORD_W'(CELL_ID)) begin
      b_mem[wr_i.col[IDX_W-1:0]] <= wr_i.value;
    end
  end

  always_comb begin
    mid_d  = tok_i;
    prod_d = a_mem[tok_i.row[IDX_W-1:0]] * b_mem[tok_i.col[IDX_W-1:0]];
    out_d  = mid_q;
    out_d.sum = mid_q.sum + smm_pkg::SUM_W'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q.valid <= 1'b0;
      out_q.valid <= 1'b0;
    end else if (en_i) begin
      mid_q  <= mid_d;
      prod_q <= prod_d;
      out_q  <= out_d;
    end
  end

  assign tok_o = out_q;

endmodule

[src/square_matrix_multiply.sv]
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    tuser: cmd; tdata: row, col, element value
// m_       out  m_tvalid/m_tready    tdata: row, col, product; tlast: last element
//
// A multiply request holds s_tready low until its last result has been taken;
// it issues one token per cycle, unless stalled by m_tready, through a chain
// of DIM cells, two register stages each (multiply, then accumulate).
// Reset clears control only; stored matrix elements are undefined until written.
// m_tready low while a result is pending freezes the whole chain and the issue counter.
module square_matrix_multiply #(
  parameter int unsigned DIM = smm_pkg::DIM_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [23:0]                 s_tdata_i,  // row[2:0], col[5:3], element_value[21:6]
  input  logic [smm_pkg::CMD_W-1:0]   s_tuser_i,  // cmd[1:0]
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [47:0]                 m_tdata_o,  // out_row[2:0], out_col[5:3], product[40:6]
  output logic                        m_tlast_o
);

  localparam int unsigned CW = smm_pkg::COORD_W;
  localparam logic [CW-1:0] MAX_IDX = CW'(DIM - 1);

  logic busy_q, busy_d;
  logic issuing_q, issuing_d;
  logic [CW-1:0] row_q, row_d, col_q, col_d;
  logic m_valid_q, m_valid_d;
  smm_pkg::tok_t m_tok_q;
  logic en;
  logic s_acc;
  logic in_range;
  smm_pkg::wr_t wr;
  smm_pkg::tok_t chain [DIM+1];

  assign en         = !m_valid_q || m_tready_i;
  assign s_tready_o = !busy_q;
  assign s_acc      = s_tvalid_i && s_tready_o;
  assign in_range   = ({1'b0, s_tdata_i[2:0]} < (CW + 1)'(DIM)) &&
                      ({1'b0, s_tdata_i[5:3]} < (CW + 1)'(DIM));

  always_comb begin
    wr.a_en  = s_acc && s_tuser_i == smm_pkg::CMD_WRITE_A && in_range;
    wr.b_en  = s_acc && s_tuser_i == smm_pkg::CMD_WRITE_B && in_range;
    wr.row   = s_tdata_i[2:0];
    wr.col   = s_tdata_i[5:3];
    wr.value = s_tdata_i[21:6];
  end

  always_comb begin
    chain[0].valid = issuing_q;
    chain[0].last  = (row_q == MAX_IDX) && (col_q == MAX_IDX);
    chain[0].row   = row_q;
    chain[0].col   = col_q;
    chain[0].sum   = '0;
  end

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    smm_cell #(
      .DIM     (DIM),
      .CELL_ID (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .wr_i   (wr),
      .tok_i  (chain[k]),
      .tok_o  (chain[k+1])
    );
  end

  always_comb begin
    busy_d    = busy_q;
    issuing_d = issuing_q;
    row_d     = row_q;
    col_d     = col_q;
    m_valid_d = m_valid_q;
    if (s_acc && s_tuser_i == smm_pkg::CMD_MULTIPLY) begin
      busy_d    = 1'b1;
      issuing_d = 1'b1;
      row_d     = '0;
      col_d     = '0;
    end else if (en && issuing_q) begin
      if (col_q == MAX_IDX) begin
        col_d = '0;
        row_d = row_q + CW'(1);
        if (row_q == MAX_IDX) begin
          issuing_d = 1'b0;
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
    if (en) begin
      m_valid_d = chain[DIM].valid;
    end
    if (m_valid_q && m_tready_i && m_tok_q.last) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      issuing_q <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      issuing_q <= issuing_d;
      row_q     <= row_d;
      col_q     <= col_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_tok_q <= chain[DIM];
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tlast_o  = m_tok_q.last;
  assign m_tdata_o  = {7'd0, m_tok_q.sum, m_tok_q.col, m_tok_q.row};

  a_idle_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !m_valid_q)
    else $error("result pending while idle");

  a_issue_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issuing_q |-> busy_q)
    else $error("issuing outside a multiply");

  a_last_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_tok_q.last) |-> !issuing_q)
    else $error("last result before issue finished");

  a_mult_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_tuser_i == smm_pkg::CMD_MULTIPLY) |=> (issuing_q && busy_q))
    else $error("multiply request did not start issue");

endmodule

[dv/tb_square_matrix_multiply.sv]
module tb_square_matrix_multiply;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N = smm_pkg::DIM_DEFAULT;
  localparam logic [smm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_REQUESTS = 25;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER = 300;
  localparam int unsigned DRAIN_CYCLES = 4 * N + 20;
  localparam int unsigned NUM_STEPS = 20;

  typedef struct packed {
    logic [smm_pkg::COORD_W-1:0]      row;
    logic [smm_pkg::COORD_W-1:0]      col;
    logic signed [smm_pkg::SUM_W-1:0] sum;
    logic                             last;
  } product_t;

  // fill: write every element of the matrix that cmd selects
  // known: every product element equals known_sum
  typedef struct packed {
    logic                          fill;
    logic [smm_pkg::CMD_W-1:0]     cmd;
    logic [smm_pkg::COORD_W-1:0]   row;
    logic [smm_pkg::COORD_W-1:0]   col;
    logic [smm_pkg::VALUE_W-1:0]   value;
    logic                          known;
    logic signed [63:0]            known_sum;
  } step_t;

  step_t steps [NUM_STEPS] = '{
    '{1'b1, smm_pkg::CMD_WRITE_A,  3'd0, 3'd0, 16'h8000, 1'b0, 64'sd0},
    '{1'b1, smm_pkg::CMD_WRITE_B,  3'd0, 3'd0, 16'h8000, 1'b0, 64'sd0},
    '{1'b0, smm_pkg::CMD_MULTIPLY, 3'd0, 3'd0, 16'h0000, 1'b1, 64'sd8589934592},
    '{1'b1, smm_pkg::CMD_WRITE_A,  3'd0, 3'd0, 16'h7fff, 1'b0, 64'sd0},
    '{1'b0, smm_pkg::CMD_MULTIPLY, 3'd7, 3'd7, 16'hffff, 1'b1, -64'sd8589672448},
    '{1'b1, smm_pkg::CMD_WRITE_B,  3'd0, 3'd0, 16'h7fff, 1'b0, 64'sd0},
    '{1'b0, smm_pkg::CMD_MULTIPLY, 3'd5, 3'd2, 16'h1234, 1'b1, 64'sd8589410312},
    '{1'b0, smm_pkg::CMD_WRITE_A,  3'd0, 3'd0, 16'h0000, 1'b0, 64'sd0},
    '{1'b0, smm_pkg::CMD_WRITE_A,  3'd7, 3'd7, 16'hffff, 1'b0, 64'sd0},
    '{1'b0, smm_pkg::CMD_WRITE_B,  3'd0, 3'd7, 16'h0001, 1'b0, 64'sd0},
    '{1'b0, smm_pkg::CMD_WRITE_B,  3'd7, 3'd0, 16'h8000, 1'b0, 64'sd0},
    '{1'b0, smm_pkg::CMD_WRITE_A,  3'd3, 3'd4, 16'h5555, 1'b0, 64'sd0},
    '{1'b0, smm_pkg::CMD_WRITE_B,  3'd4, 3'd3, 16'haaaa, 1'b0, 64'sd0},
    '{1'b0, CMD_UNUSED,            3'd5, 3'd2, 16'hffff, 1'b0, 64'sd0},
    '{1'b0, CMD_UNUSED,            3'd2, 3'd5, 16'h0000, 1'b0, 64'sd0},
    '{1'b0, smm_pkg::CMD_MULTIPLY, 3'd2, 3'd5, 16'haaaa, 1'b0, 64'sd0},
    '{1'b1, smm_pkg::CMD_WRITE_A,  3'd0, 3'd0, 16'h0000, 1'b0, 64'sd0},
    '{1'b0, smm_pkg::CMD_MULTIPLY, 3'd0, 3'd0, 16'h0000, 1'b1, 64'sd0},
    '{1'b0, smm_pkg::CMD_WRITE_B,  3'd6, 3'd1, 16'h8001, 1'b0, 64'sd0},
    '{1'b0, smm_pkg::CMD_MULTIPLY, 3'd7, 3'd0, 16'h5555, 1'b0, 64'sd0}
  };

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         s_tvalid_i = 1'b0;
  logic                         s_tready_o;
  logic [23:0]                  s_tdata_i = '0;  // row[2:0], col[5:3], element_value[21:6]
  logic [smm_pkg::CMD_W-1:0]    s_tuser_i = '0;  // cmd[1:0]
  logic                         m_tvalid_o;
  logic                         m_tready_i = 1'b0;
  logic [47:0]                  m_tdata_o;       // out_row[2:0], out_col[5:3], product[40:6]
  logic                         m_tlast_o;

  logic signed [smm_pkg::VALUE_W-1:0] a_elem [N][N];
  logic signed [smm_pkg::VALUE_W-1:0] b_elem [N][N];
  product_t expected_products [$];
  int unsigned errors = 0;
  int unsigned products_seen = 0;
  int unsigned burst_left = 0;

  square_matrix_multiply #(.DIM(N)) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tlast_o (m_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at product %0d", what, got, want,
             products_seen);
  endtask

  task automatic queue_products(input logic known, input logic signed [63:0] known_sum);
    product_t p;
    longint acc;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        acc = 0;
        for (int k = 0; k < N; k++)
          acc += longint'(a_elem[i][k]) * longint'(b_elem[k][j]);
        p.row  = i[smm_pkg::COORD_W-1:0];
        p.col  = j[smm_pkg::COORD_W-1:0];
        p.sum  = known ? known_sum[smm_pkg::SUM_W-1:0] : acc[smm_pkg::SUM_W-1:0];
        p.last = (i == N - 1) && (j == N - 1);
        expected_products.push_back(p);
      end
    end
  endtask

  // drive one request, hold it until taken, then update the predicted stores
  task automatic send_request(input logic [smm_pkg::CMD_W-1:0] cmd,
                              input logic [smm_pkg::COORD_W-1:0] row,
                              input logic [smm_pkg::COORD_W-1:0] col,
                              input logic [smm_pkg::VALUE_W-1:0] value,
                              input logic known, input logic signed [63:0] known_sum);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {2'b00, value, col, row};
    s_tuser_i  <= cmd;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    if (cmd == smm_pkg::CMD_WRITE_A && row < N && col < N)
      a_elem[row][col] = value;
    else if (cmd == smm_pkg::CMD_WRITE_B && row < N && col < N)
      b_elem[row][col] = value;
    else if (cmd == smm_pkg::CMD_MULTIPLY)
      queue_products(known, known_sum);
  endtask

  initial begin : stimulus
    int unsigned pick;
    logic [smm_pkg::CMD_W-1:0] cmd;
    logic [smm_pkg::VALUE_W-1:0] value;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[s]) begin
      if (steps[s].fill) begin
        for (int r = 0; r < N; r++)
          for (int c = 0; c < N; c++)
            send_request(steps[s].cmd, r[smm_pkg::COORD_W-1:0], c[smm_pkg::COORD_W-1:0],
                         steps[s].value, 1'b0, 64'sd0);
      end else begin
        send_request(steps[s].cmd, steps[s].row, steps[s].col, steps[s].value,
                     steps[s].known, steps[s].known_sum);
      end
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 42)      cmd = smm_pkg::CMD_WRITE_A;
      else if (pick < 84) cmd = smm_pkg::CMD_WRITE_B;
      else if (pick < 93) cmd = smm_pkg::CMD_MULTIPLY;
      else                cmd = CMD_UNUSED;
      case ($urandom_range(0, 9))
        0:       value = 16'h8000;
        1:       value = 16'h7fff;
        2:       value = {smm_pkg::VALUE_W{$urandom_range(0, 1) == 1}};
        default: value = smm_pkg::VALUE_W'($urandom);
      endcase
      send_request(cmd, smm_pkg::COORD_W'($urandom_range(0, N - 1)),
                   smm_pkg::COORD_W'($urandom_range(0, N - 1)), value, 1'b0, 64'sd0);
    end
    s_tvalid_i <= 1'b0;

    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // result side: changing stall patterns, with one long hold-off once HOLD_AFTER products are seen
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    bit hold_done;
    mode = 0;
    span = 0;
    tick = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (!hold_done && products_seen >= HOLD_AFTER) begin
        m_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(16, 128);
        end
        span--;
        case (mode)
          0:       m_tready_i <= 1'b1;
          1:       m_tready_i <= ($urandom_range(0, 1) == 1);
          2:       m_tready_i <= (tick % 4 == 0);
          default: m_tready_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : product_check
    product_t got;
    product_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got.row  = m_tdata_o[2:0];
      got.col  = m_tdata_o[5:3];
      got.sum  = m_tdata_o[40:6];
      got.last = m_tlast_o;
      if (expected_products.size() == 0) begin
        report("unexpected product", longint'(got.sum), 0);
      end else begin
        want = expected_products.pop_front();
        if (got.row !== want.row)   report("out_row", got.row, want.row);
        if (got.col !== want.col)   report("out_col", got.col, want.col);
        if (got.sum !== want.sum)   report("product", longint'(got.sum), longint'(want.sum));
        if (got.last !== want.last) report("last", got.last, want.last);
      end
      products_seen++;
    end
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned idle;
    if (!rst_ni) begin
      idle = 0;
    end else if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      idle = 0;
    end else begin
      idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

[files.f]
src/smm_pkg.sv
src/smm_cell.sv
src/square_matrix_multiply.sv
dv/tb_square_matrix_multiply.sv
